// ----- design/sws_pkg.sv -----
package sws_pkg;

    localparam int unsigned VAL_W = 32;
    localparam int unsigned TGT_W = 40;
    localparam int unsigned SUM_W = 41;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = 2;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_TOO_LONG  = 2'd2
    } t_status;

    // classification the front attaches to each element
    typedef struct packed {
        logic last;
        logic overflow;
    } t_cls;

endpackage

// ----- design/sws_queue.sv -----
module sws_queue #(
    parameter int unsigned DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);
    import sws_pkg::*;

    logic [DW-1:0] r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, r_rptr;
    logic [Q_AW:0]   r_cnt;

    logic do_push, do_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count beyond depth");

    ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != (Q_AW+1)'(Q_DEPTH)) |-> (Q_AW'(r_wptr - r_rptr) == r_cnt[Q_AW-1:0]))
        else $error("queue pointers disagree with count");

    pop_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |=> (r_cnt == '0) || $past(i_push))
        else $error("queue filled without push");

endmodule

// ----- design/sws_front.sv -----
module sws_front #(
    parameter int unsigned MAX_LEN = 4096,
    parameter int unsigned AW      = 12,
    parameter int unsigned PW      = 13
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [31:0]            i_s_tdata,
    input  logic                   i_s_tlast,
    input  logic                   i_full,
    output logic                   o_push,
    output logic [31:0]            o_value,
    output sws_pkg::t_cls          o_cls,
    output logic [AW-1:0]          o_idx
);
    import sws_pkg::*;

    // elements taken in the current array, saturating at MAX_LEN
    logic [PW-1:0] r_count;
    logic          ovf;

    assign ovf        = (r_count >= PW'(MAX_LEN));
    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;
    assign o_value    = i_s_tdata;
    assign o_cls      = '{last: i_s_tlast, overflow: ovf};
    assign o_idx      = r_count[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            if (i_s_tlast) begin
                r_count <= '0;
            end else if (!ovf) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= PW'(MAX_LEN))
        else $error("element count beyond limit");

    count_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_s_tlast) |=> (r_count == '0))
        else $error("count not cleared after final element");

    count_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_push |=> $stable(r_count))
        else $error("count moved without request");

endmodule

// ----- design/sws_back.sv -----
module sws_back #(
    parameter int unsigned MAX_LEN = 4096,
    parameter int unsigned AW      = 12,
    parameter int unsigned PW      = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sws_pkg::TGT_W-1:0]     i_target,
    input  logic                          i_q_valid,
    input  logic [31:0]                   i_q_value,
    input  sws_pkg::t_cls                 i_q_cls,
    input  logic [AW-1:0]                 i_q_idx,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output sws_pkg::t_status              o_status,
    output logic [PW-1:0]                 o_start,
    output logic [PW-1:0]                 o_end
);
    import sws_pkg::*;

    typedef enum logic [2:0] {
        S_TAKE  = 3'b001,
        S_CHECK = 3'b010,
        S_SUB   = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [PW-1:0]     r_front, n_front;
    logic [PW-1:0]     r_seen, n_seen;
    logic              r_answered, n_answered;
    logic              r_last, n_last;
    logic [VAL_W-1:0]  r_rd_data;
    logic [VAL_W-1:0]  r_store [MAX_LEN];

    logic              r_out_valid;
    t_status           r_status;
    logic [PW-1:0]     r_start, r_end;

    logic              out_free, wr, load;
    t_status           ld_status;
    logic [PW-1:0]     ld_start, ld_end;
    logic [SUM_W-1:0]  tgt_ext;
    logic              win_nonempty;

    assign out_free     = !r_out_valid || i_ready;
    assign tgt_ext      = SUM_W'(i_target);
    assign win_nonempty = (r_front < r_seen);

    always_comb begin
        n_state    = r_state;
        n_sum      = r_sum;
        n_front    = r_front;
        n_seen     = r_seen;
        n_answered = r_answered;
        n_last     = r_last;
        o_q_pop    = 1'b0;
        wr         = 1'b0;
        load       = 1'b0;
        ld_status  = ST_FOUND;
        ld_start   = '0;
        ld_end     = '0;
        unique case (r_state)
            S_TAKE: begin
                if (i_q_valid) begin
                    if (r_answered) begin
                        // rest of an answered array is dropped
                        o_q_pop = 1'b1;
                        if (i_q_cls.last) begin
                            n_sum      = '0;
                            n_front    = '0;
                            n_seen     = '0;
                            n_answered = 1'b0;
                        end
                    end else if (i_q_cls.overflow) begin
                        if (!i_q_cls.last) begin
                            o_q_pop = 1'b1;
                        end else if (out_free) begin
                            o_q_pop   = 1'b1;
                            load      = 1'b1;
                            ld_status = ST_TOO_LONG;
                            n_sum     = '0;
                            n_front   = '0;
                            n_seen    = '0;
                        end
                    end else begin
                        o_q_pop = 1'b1;
                        wr      = 1'b1;
                        n_sum   = r_sum + SUM_W'(i_q_value);
                        n_seen  = PW'(i_q_idx) + 1'b1;
                        n_last  = i_q_cls.last;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_sum > tgt_ext && win_nonempty) begin
                    n_state = S_SUB;
                end else if (win_nonempty && r_sum == tgt_ext) begin
                    if (out_free) begin
                        load       = 1'b1;
                        ld_status  = ST_FOUND;
                        ld_start   = r_front + 1'b1;
                        ld_end     = r_seen;
                        n_answered = !r_last;
                        if (r_last) begin
                            n_sum   = '0;
                            n_front = '0;
                            n_seen  = '0;
                        end
                        n_state = S_TAKE;
                    end
                end else if (r_last) begin
                    if (out_free) begin
                        load      = 1'b1;
                        ld_status = ST_NOT_FOUND;
                        n_sum     = '0;
                        n_front   = '0;
                        n_seen    = '0;
                        n_state   = S_TAKE;
                    end
                end else begin
                    n_state = S_TAKE;
                end
            end
            S_SUB: begin
                n_sum   = r_sum - SUM_W'(r_rd_data);
                n_front = r_front + 1'b1;
                n_state = S_CHECK;
            end
            default: begin
                n_state = S_TAKE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_TAKE;
            r_sum       <= '0;
            r_front     <= '0;
            r_seen      <= '0;
            r_answered  <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sum      <= n_sum;
            r_front    <= n_front;
            r_seen     <= n_seen;
            r_answered <= n_answered;
            r_last     <= n_last;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= ld_status;
            r_start  <= ld_start;
            r_end    <= ld_end;
        end
    end

    // window store: write on take, front entry read every cycle
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_store[i_q_idx] <= i_q_value;
        end
        r_rd_data <= r_store[r_front[AW-1:0]];
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_start  = r_start;
    assign o_end    = r_end;

    front_le_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= r_seen)
        else $error("window front passed window end");

    sub_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUB) |-> ($past(r_state) == S_CHECK))
        else $error("drop step not preceded by check");

    found_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && ld_status == ST_FOUND) |-> (ld_start <= ld_end && ld_start != '0))
        else $error("found result with bad positions");

    no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !load)
        else $error("result overwritten while waiting");

endmodule

// ----- design/sliding_window_target_sum.sv -----
// Channel     | Dir | Signals                          | Carries
// s (element) | in  | i_s_tvalid/o_s_tready, tdata,tlast| tdata[31:0] element_value; tlast last_item
// m (result)  | out | o_m_tvalid/i_m_tready, tdata,tuser| tuser[1:0] status; tdata start, end
// cfg         | in  | i_cfg_valid/o_cfg_ready, data    | i_cfg_data[39:0] target_sum
//
// Each stored element takes an add step and a compare step in the search engine, plus a
// store read, subtract and compare for every element dropped from the window front; elements past
// a match or past MAX_LEN only pass the take step. The registered read of the window store sets the
// drop cost. A 4-entry queue lets the input keep taking elements while the engine is busy.
// The result register holds one result; the engine stalls only when it must emit into a
// full result register. Reset is synchronous active low; no store clearing pass is needed.
module sliding_window_target_sum #(
    parameter int unsigned MAX_LEN = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [31:0]                            i_s_tdata,   // [31:0] element_value
    input  logic                                   i_s_tlast,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // [PW-1:0] start_position, [2*PW-1:PW] end_position, zero padded to bytes
    output logic [((2*$clog2(MAX_LEN+1)+7)/8)*8-1:0] o_m_tdata,
    output logic [1:0]                             o_m_tuser,   // [1:0] status
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [39:0]                            i_cfg_data
);
    import sws_pkg::*;

    localparam int unsigned AW     = $clog2(MAX_LEN);
    localparam int unsigned PW     = $clog2(MAX_LEN + 1);
    localparam int unsigned OUT_DW = ((2 * PW + 7) / 8) * 8;
    localparam int unsigned QDW    = AW + 2 + VAL_W;

    logic [TGT_W-1:0] r_target;

    logic              push, full, q_valid, q_pop;
    logic [31:0]       f_value;
    t_cls              f_cls, q_cls;
    logic [AW-1:0]     f_idx, q_idx;
    logic [QDW-1:0]    q_din, q_dout;
    logic [31:0]       q_value;
    t_status           status;
    logic [PW-1:0]     start_pos, end_pos;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_valid) begin
            r_target <= i_cfg_data;
        end
    end

    sws_front #(.MAX_LEN(MAX_LEN), .AW(AW), .PW(PW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_full     (full),
        .o_push     (push),
        .o_value    (f_value),
        .o_cls      (f_cls),
        .o_idx      (f_idx)
    );

    assign q_din = {f_idx, f_cls, f_value};

    sws_queue #(.DW(QDW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_din),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_dout)
    );

    assign q_value = q_dout[VAL_W-1:0];
    assign q_cls   = q_dout[VAL_W+1:VAL_W];
    assign q_idx   = q_dout[QDW-1:VAL_W+2];

    sws_back #(.MAX_LEN(MAX_LEN), .AW(AW), .PW(PW)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_target  (r_target),
        .i_q_valid (q_valid),
        .i_q_value (q_value),
        .i_q_cls   (q_cls),
        .i_q_idx   (q_idx),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_status  (status),
        .o_start   (start_pos),
        .o_end     (end_pos)
    );

    assign o_m_tuser = status;
    assign o_m_tdata = OUT_DW'({end_pos, start_pos});

endmodule

// ----- sim/tb_sliding_window_target_sum.sv -----
module tb_sliding_window_target_sum;
    import sws_pkg::*;

    localparam int MAX_LEN        = 4096;
    localparam int PW             = $clog2(MAX_LEN + 1);
    localparam int RES_W          = ((2 * PW + 7) / 8) * 8;
    localparam int SETTLE_CYCLES  = 64;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int RANDOM_BUDGET  = 185;
    localparam logic [TGT_W-1:0] TARGET_MAX = '1;

    typedef struct {
        t_status          status;
        logic [PW-1:0]    start_pos;
        logic [PW-1:0]    stop_pos;
    } search_result_t;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_s_tvalid  = 1'b0;
    logic               o_s_tready;
    logic [VAL_W-1:0]   i_s_tdata   = '0;     // [31:0] element_value
    logic               i_s_tlast   = 1'b0;   // last_item
    logic               o_m_tvalid;
    logic               i_m_tready  = 1'b0;
    logic [RES_W-1:0]   o_m_tdata;            // [12:0] start_position, [25:13] end_position
    logic [1:0]         o_m_tuser;            // [1:0] status
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [TGT_W-1:0]   i_cfg_data  = '0;

    // model of the search engine
    logic [VAL_W-1:0]   win_store [0:MAX_LEN-1];
    logic [SUM_W-1:0]   win_sum      = '0;
    int                 win_front    = 0;
    int                 win_count    = 0;
    bit                 win_answered = 1'b0;
    logic [TGT_W-1:0]   target_reg   = '0;

    search_result_t     pending_results [$];
    logic [VAL_W-1:0]   batch [$];
    int                 error_count = 0;
    int                 burst_left  = 0;
    int                 stall_mode  = 0;
    int                 stall_left  = 0;

    sliding_window_target_sum #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("tb_sliding_window_target_sum: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // two-pointer search, updated on every accepted element
    task automatic search_window(input logic [VAL_W-1:0] value, input logic is_last);
        search_result_t res;
        if (!win_answered) begin
            if (win_count >= MAX_LEN) begin
                win_count = MAX_LEN + 1;
            end else begin
                win_store[win_count] = value;
                win_count++;
                win_sum += SUM_W'(value);
                while (win_sum > SUM_W'(target_reg) && win_front < win_count) begin
                    win_sum -= SUM_W'(win_store[win_front]);
                    win_front++;
                end
                // an empty window never matches, even for a zero target
                if (win_front < win_count && win_sum == SUM_W'(target_reg)) begin
                    res = '{ST_FOUND, PW'(win_front + 1), PW'(win_count)};
                    pending_results.insert(pending_results.size(), res);
                    win_answered = 1'b1;
                end
            end
            if (is_last && !win_answered) begin
                res = '{(win_count > MAX_LEN) ? ST_TOO_LONG : ST_NOT_FOUND, '0, '0};
                pending_results.insert(pending_results.size(), res);
            end
        end
        if (is_last) begin
            win_sum      = '0;
            win_front    = 0;
            win_count    = 0;
            win_answered = 1'b0;
        end
    endtask

    task automatic check_result();
        search_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result status=%0d start=%0d end=%0d",
                                      o_m_tuser, o_m_tdata[PW-1:0], o_m_tdata[2*PW-1:PW]));
        end else begin
            want = pending_results.pop_front();
            if (o_m_tuser !== want.status)
                report_mismatch($sformatf("status %0d, expected %s", o_m_tuser,
                                          want.status.name()));
            if (o_m_tdata[PW-1:0] !== want.start_pos)
                report_mismatch($sformatf("start_position %0d, expected %0d",
                                          o_m_tdata[PW-1:0], want.start_pos));
            if (o_m_tdata[2*PW-1:PW] !== want.stop_pos)
                report_mismatch($sformatf("end_position %0d, expected %0d",
                                          o_m_tdata[2*PW-1:PW], want.stop_pos));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            check_result();
        end
    end

    // result side back-pressure: a random mode, redrawn when stall_left runs out
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 256);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= $urandom_range(0, 1);
            2: i_m_tready <= ($urandom_range(0, 5) == 0);
            default: i_m_tready <= (stall_left % 4 == 0);
        endcase
    end

    task automatic send_element(input logic [VAL_W-1:0] value, input logic is_last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tlast  <= is_last;
        do @(posedge i_clk); while (!o_s_tready);
        search_window(value, is_last);
    endtask

    task automatic send_batch();
        foreach (batch[i]) begin
            send_element(batch[i], i == batch.size() - 1);
        end
    endtask

    // holds the input until every pending result is back, then lets trailing
    // ignored elements drain out of the input queue
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_target(input logic [TGT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        target_reg = value;
    endtask

    function automatic logic [VAL_W-1:0] rand_upto(input longint unsigned cap);
        if (cap >= 64'hFFFF_FFFF) return $urandom;
        return $urandom_range(0, 32'(cap));
    endfunction

    function automatic logic [VAL_W-1:0] pick_element(input longint unsigned target);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return $urandom;
            3, 4, 5, 6: return rand_upto(target / 4);
            default: return rand_upto(target);
        endcase
    endfunction

    task automatic build_array(input longint unsigned target);
        longint unsigned remaining;
        logic [VAL_W-1:0] part;
        batch.delete();
        if ($urandom_range(0, 99) < 65) begin
            repeat ($urandom_range(0, 6)) batch.insert(batch.size(), pick_element(target));
            // planted run that sums exactly to the target
            remaining = target;
            do begin
                if (remaining <= 64'hFFFF_FFFF && $urandom_range(0, 2) == 0)
                    part = VAL_W'(remaining);
                else
                    part = rand_upto(remaining);
                batch.insert(batch.size(), part);
                remaining -= part;
            end while (remaining != 0);
            repeat ($urandom_range(0, 4)) batch.insert(batch.size(), pick_element(target));
        end else begin
            repeat ($urandom_range(1, 24)) batch.insert(batch.size(), pick_element(target));
        end
    endtask

    task automatic send_long_array(input int count, input logic [VAL_W-1:0] lo,
                                   input logic [VAL_W-1:0] hi);
        for (int i = 0; i < count; i++) begin
            send_element($urandom_range(lo, hi), i == count - 1);
        end
    endtask

    // target still at its reset value of zero
    task automatic test_zero_target();
        batch = {32'd0};
        send_batch();
        batch = {32'd5};
        send_batch();
        batch = {32'd5, 32'd0, 32'd0};
        send_batch();
        batch = {32'hFFFF_FFFF};
        send_batch();
        drain_results();
    endtask

    task automatic test_small_target();
        set_target(40'd10);
        batch = {32'd3, 32'd4, 32'd3, 32'd9};
        send_batch();
        batch = {32'd20, 32'd10};
        send_batch();
        batch = {32'd1, 32'd2, 32'd3};
        send_batch();
        batch = {32'd4, 32'd6, 32'd7, 32'd3};
        send_batch();
        drain_results();
    endtask

    // sums past 32 bits and the widest target
    task automatic test_wide_sums();
        set_target(TARGET_MAX);
        batch = {32'hFFFF_FFFF, 32'hFFFF_FFFF};
        send_batch();
        drain_results();
        set_target(40'h1_FFFF_FFFE);
        batch = {32'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1};
        send_batch();
        drain_results();
    endtask

    // match closes on the last slot of the store
    task automatic test_full_window();
        set_target(40'(MAX_LEN));
        send_long_array(MAX_LEN, 32'd1, 32'd1);
        drain_results();
    endtask

    // store fills with no match, the rest of the array overflows
    task automatic test_length_limit();
        set_target(TARGET_MAX);
        send_long_array(MAX_LEN + 4, 32'd0, 32'h0010_0000);
        drain_results();
    endtask

    task automatic test_random_arrays();
        logic [TGT_W-1:0] phase_target [9];
        int sent;
        phase_target[0] = '0;
        phase_target[1] = 40'd1;
        phase_target[2] = 40'($urandom_range(2, 1000));
        phase_target[3] = 40'($urandom_range(1000, 32'h0010_0000));
        phase_target[4] = 40'($urandom);
        phase_target[5] = {8'($urandom_range(1, 255)), 32'($urandom)};
        phase_target[6] = TARGET_MAX;
        phase_target[7] = 40'($urandom_range(2, 60));
        phase_target[8] = '0;
        foreach (phase_target[p]) begin
            set_target(phase_target[p]);
            sent = 0;
            while (sent < RANDOM_BUDGET) begin
                build_array(longint'(phase_target[p]));
                sent += batch.size();
                send_batch();
            end
            drain_results();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_target();
        test_small_target();
        test_wide_sums();
        test_full_window();
        test_length_limit();
        test_random_arrays();
        if (error_count == 0) begin
            $display("tb_sliding_window_target_sum: PASS");
        end else begin
            $display("tb_sliding_window_target_sum: FAIL");
        end
        $finish;
    end

endmodule
